// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: whenever ante holds, cons must follow as written.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Invariant check: expr must never hold outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed: forbidden condition");

`endif

// File: hdl/crv_pkg.sv
// ----------------------------------------------------------------------------
// crv_pkg
// Transaction types and arctangent table for the CORDIC rotate/vector core.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned ATAN_ENTRIES = 29;

  // func codes
  localparam logic FUNC_ROTATE = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  // atan(2^-i) in degrees, scaled by 2^22
  localparam logic [FIELD_W-1:0] ATAN_Q22 [ATAN_ENTRIES] = '{
    32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
    32'd7507429,   32'd3754631,   32'd1877430,  32'd938729,   32'd469366,
    32'd234683,    32'd117342,    32'd58671,    32'd29335,    32'd14668,
    32'd7334,      32'd3667,      32'd1833,     32'd917,      32'd458,
    32'd229,       32'd115,       32'd57,       32'd29,       32'd14,
    32'd7,         32'd4,         32'd2,        32'd1
  };

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] x_in;
    logic [FIELD_W-1:0] y_in;
    logic [FIELD_W-1:0] z_in;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] x_out;
    logic [FIELD_W-1:0] y_out;
    logic [FIELD_W-1:0] z_out;
  } res_t;

  // Control travelling alongside the datapath of each stage
  typedef struct packed {
    logic valid;
    logic func;
  } ctrl_t;

endpackage

// File: hdl/cordic_rotate_vector_core.sv
// ----------------------------------------------------------------------------
// cordic_rotate_vector_core
// Circular CORDIC, rotation and vectoring modes, fully pipelined.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start_i is high; busy_o stays low because
// every micro-rotation has its own register stage and nothing feeds back, so
// one transaction per cycle is sustained. The result appears on res_o with
// done_o high for one cycle once it has passed one register stage per
// micro-rotation, in order. The receiver cannot stall and the core never
// needs it to. Gain is not removed from x, y.
// ----------------------------------------------------------------------------
module cordic_rotate_vector_core #(
  parameter int unsigned ITERATIONS = 29,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  crv_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output crv_pkg::res_t res_o
);

  crv_pkg::ctrl_t        ctrl_s [ITERATIONS+1];
  logic [DATA_WIDTH-1:0] x_s    [ITERATIONS+1];
  logic [DATA_WIDTH-1:0] y_s    [ITERATIONS+1];
  logic [DATA_WIDTH-1:0] z_s    [ITERATIONS+1];

  assign busy_o = 1'b0;

  // narrow datapath keeps the low bits of each coordinate
  assign ctrl_s[0].valid = start_i && !busy_o;
  assign ctrl_s[0].func  = req_i.func;
  assign x_s[0] = req_i.x_in[DATA_WIDTH-1:0];
  assign y_s[0] = req_i.y_in[DATA_WIDTH-1:0];
  assign z_s[0] = req_i.z_in[DATA_WIDTH-1:0];

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
    crv_stage #(
      .DW    (DATA_WIDTH),
      .SHIFT (g),
      .ANGLE (crv_pkg::ATAN_Q22[g][DATA_WIDTH-1:0])
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
  end

  assign done_o = ctrl_s[ITERATIONS].valid;

  // sign-extend back to the field width
  always_comb begin
    res_o.x_out = crv_pkg::FIELD_W'($signed(x_s[ITERATIONS]));
    res_o.y_out = crv_pkg::FIELD_W'($signed(y_s[ITERATIONS]));
    res_o.z_out = crv_pkg::FIELD_W'($signed(z_s[ITERATIONS]));
  end

endmodule

// File: hdl/crv_stage.sv
// ----------------------------------------------------------------------------
// crv_stage
// One registered CORDIC micro-rotation: shift-add on x and y, angle step on z.
// ----------------------------------------------------------------------------
module crv_stage #(
  parameter int unsigned     DW    = 32,
  parameter int unsigned     SHIFT = 0,
  parameter logic [DW-1:0]   ANGLE = '0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crv_pkg::ctrl_t ctrl_i,
  input  logic [DW-1:0]  x_i,
  input  logic [DW-1:0]  y_i,
  input  logic [DW-1:0]  z_i,
  output crv_pkg::ctrl_t ctrl_o,
  output logic [DW-1:0]  x_o,
  output logic [DW-1:0]  y_o,
  output logic [DW-1:0]  z_o
);

  crv_pkg::ctrl_t ctrl_q;
  logic [DW-1:0]  x_d, y_d, z_d;
  logic [DW-1:0]  x_q, y_q, z_q;
  logic [DW-1:0]  xs, ys;
  logic           pos_dir;

  // a shift at or beyond the width leaves only sign bits
  assign xs = $signed(x_i) >>> SHIFT;
  assign ys = $signed(y_i) >>> SHIFT;

  assign pos_dir = (ctrl_i.func == crv_pkg::FUNC_VECTOR) ? !y_i[DW-1] : z_i[DW-1];

  always_comb begin
    if (pos_dir) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANGLE;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // hold payload when the slot is empty
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// File: hdl/crv_checker.sv
// ----------------------------------------------------------------------------
// crv_checker
// Port-level checks on transaction timing of the CORDIC core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crv_checker #(
  parameter int unsigned LATENCY = 29
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i
);

  `ASSERT_NEVER(a_never_busy, busy_i)
  `ASSERT_IMPLIES(a_start_gives_done, start_i && !busy_i, ##LATENCY done_i)
  `ASSERT_IMPLIES(a_done_has_start, done_i, $past(start_i, LATENCY))

endmodule

bind cordic_rotate_vector_core crv_checker #(
  .LATENCY (ITERATIONS)
) u_crv_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o)
);

// File: tb/cordic_rotate_vector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cordic_rotate_vector_core_tb
// Self-checking bench for the pipelined circular CORDIC core.
// A local bit-true CORDIC computes each result when its transaction is
// accepted. The result is queued and matched in order against every done_o
// strobe. Stimulus runs in bursts with random gaps. It covers directed corner
// values, then rotation, vectoring and mixed random traffic.
// ----------------------------------------------------------------------------
module cordic_rotate_vector_core_tb;

  localparam int unsigned N_STAGES  = 29;
  localparam logic signed [crv_pkg::FIELD_W-1:0] ONE_Q22 = 32'sd4194304;
  localparam logic signed [crv_pkg::FIELD_W-1:0] DEG     = 32'sd4194304;
  localparam logic signed [crv_pkg::FIELD_W-1:0] S_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [crv_pkg::FIELD_W-1:0] S_MIN   = 32'sh8000_0000;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  crv_pkg::req_t req_i;
  logic          busy_o;
  logic          done_o;
  crv_pkg::res_t res_o;

  crv_pkg::res_t pending_res_q[$];
  int unsigned   mismatch_cnt;
  int unsigned   burst_left;

  cordic_rotate_vector_core #(
    .ITERATIONS(N_STAGES),
    .DATA_WIDTH(crv_pkg::FIELD_W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bit-true micro-rotation chain; sums wrap at the field width.
  function automatic crv_pkg::res_t cordic_result(crv_pkg::req_t r);
    logic signed [crv_pkg::FIELD_W-1:0] x, y, z, xs, ys;
    logic                               ccw;
    crv_pkg::res_t                      res;
    x = r.x_in;
    y = r.y_in;
    z = r.z_in;
    for (int i = 0; i < N_STAGES; i++) begin
      xs  = x >>> i;
      ys  = y >>> i;
      ccw = (r.func == crv_pkg::FUNC_VECTOR) ? !y[crv_pkg::FIELD_W-1]
                                             : z[crv_pkg::FIELD_W-1];
      if (ccw) begin
        x = x + ys;
        y = y - xs;
        z = z + crv_pkg::ATAN_Q22[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - crv_pkg::ATAN_Q22[i];
      end
    end
    res.x_out = x;
    res.y_out = y;
    res.z_out = z;
    return res;
  endfunction

  function automatic crv_pkg::req_t make_req(logic func,
                                             logic [crv_pkg::FIELD_W-1:0] x,
                                             logic [crv_pkg::FIELD_W-1:0] y,
                                             logic [crv_pkg::FIELD_W-1:0] z);
    crv_pkg::req_t r;
    r.func = func;
    r.x_in = x;
    r.y_in = y;
    r.z_in = z;
    return r;
  endfunction

  // Mostly in-range operands with random content, some tiny, some raw noise.
  function automatic crv_pkg::req_t random_req(logic func);
    crv_pkg::req_t r;
    r.func = func;
    case ($urandom_range(0, 9))
      0, 1: begin
        r.x_in = $urandom;
        r.y_in = $urandom;
        r.z_in = $urandom;
      end
      2: begin
        r.x_in = int'($urandom_range(0, 2047)) - 1024;
        r.y_in = int'($urandom_range(0, 2047)) - 1024;
        r.z_in = int'($urandom_range(0, 2047)) - 1024;
      end
      default: begin
        r.x_in = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
        r.y_in = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
        r.z_in = int'($urandom_range(0, 838860800)) - 419430400;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [crv_pkg::FIELD_W-1:0] got,
                                 logic [crv_pkg::FIELD_W-1:0] want);
    mismatch_cnt++;
    $display("%0t ns: %s got %08h want %08h", $time, what, got, want);
  endtask

  // Hold start_i high across a burst; drop it only for a non-empty gap.
  task automatic issue_txn(input crv_pkg::req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_res_q.push_back(cordic_result(r));
  endtask

  task automatic test_directed();
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, 0, 0, 0));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, 0, 0, 0));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, ONE_Q22, 0, 30 * DEG));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, ONE_Q22, 0, -45 * DEG));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, ONE_Q22, 0, 90 * DEG));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, 0, ONE_Q22, -90 * DEG));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, ONE_Q22, ONE_Q22, 0));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, ONE_Q22, -ONE_Q22, 0));
    // y exactly zero steers as non-negative
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, -ONE_Q22, 0, 0));
    // wrap-around at the extremes of every field
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, S_MAX, S_MAX, S_MAX));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, S_MIN, S_MIN, S_MIN));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, S_MIN, S_MAX, 0));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, S_MAX, S_MIN, S_MIN));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, -1, -1, -1));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, -1, -1, S_MAX));
    issue_txn(make_req(crv_pkg::FUNC_ROTATE, S_MAX, S_MIN, 180 * DEG));
    issue_txn(make_req(crv_pkg::FUNC_VECTOR, 1, -1, S_MIN));
  endtask

  task automatic test_rotation_random(int unsigned n);
    repeat (n) issue_txn(random_req(crv_pkg::FUNC_ROTATE));
  endtask

  task automatic test_vectoring_random(int unsigned n);
    repeat (n) issue_txn(random_req(crv_pkg::FUNC_VECTOR));
  endtask

  task automatic test_mixed_random(int unsigned n);
    repeat (n) begin
      issue_txn(random_req($urandom_range(0, 1) ? crv_pkg::FUNC_VECTOR
                                                 : crv_pkg::FUNC_ROTATE));
    end
  endtask

  // Match each strobed result against the oldest queued one.
  always @(posedge clk_i) begin
    crv_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_res_q.size() == 0) begin
        report_mismatch("unexpected result x_out", res_o.x_out, '0);
      end else begin
        want = pending_res_q.pop_front();
        if (res_o.x_out !== want.x_out) report_mismatch("x_out", res_o.x_out, want.x_out);
        if (res_o.y_out !== want.y_out) report_mismatch("y_out", res_o.y_out, want.y_out);
        if (res_o.z_out !== want.z_out) report_mismatch("z_out", res_o.z_out, want.z_out);
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    req_i        <= '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rotation_random(500);
    test_vectoring_random(500);
    test_mixed_random(700);

    start_i <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (N_STAGES + 10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/crv_pkg.sv
hdl/crv_stage.sv
hdl/cordic_rotate_vector_core.sv
hdl/crv_checker.sv
tb/cordic_rotate_vector_core_tb.sv
